/* rtl/dsd_pkg.sv */
// Shared types and constants for the shortest-distance core.
package dsd_pkg;

   localparam int CMD_W    = 3;
   localparam int NODE_W   = 9;
   localparam int OFFSET_W = 13;
   localparam int NBR_W    = 8;
   localparam int WEIGHT_W = 16;
   localparam int TAG_W    = 8;
   localparam int DIST_W   = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int EDGE_W   = NBR_W + WEIGHT_W;

   localparam logic [DIST_W-1:0] DIST_ONES = {DIST_W{1'b1}};

   localparam logic [CMD_W-1:0] CMD_WR_OFFSET = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WR_EDGE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WR_TAG    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RUN       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_EN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_TAG = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [NODE_W-1:0]   node;
      logic [OFFSET_W-1:0] offset;
      logic [NBR_W-1:0]    nbr;
      logic [WEIGHT_W-1:0] weight;
      logic [TAG_W-1:0]    tag;
      logic                err;
   } item_type;

   typedef struct packed {
      logic [NODE_W-1:0] node_lim;
      logic              filter_en;
      logic [TAG_W-1:0]  filter_tag;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD_DONE, ST_RUN_INIT, ST_POP, ST_POP_TOP, ST_POP_LAST,
      ST_SIFT, ST_SIFT_L, ST_SIFT_R, ST_SIFT_CMP, ST_CHECK, ST_CHECK_DIST,
      ST_ROW_S, ST_ROW_E, ST_EDGE, ST_EDGE_RD, ST_RELAX, ST_PUSH, ST_PUSH_CMP,
      ST_RUN_DONE
   } state_type;

endpackage

/* rtl/dsd_ram.sv */
// Generic simple dual-port RAM with registered read.
module dsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

/* rtl/dsd_front.sv */
// Front end: configuration registers, command checking and a two-word queue.
module dsd_front #(
   parameter int MAX_NODES = 256,
   parameter int MAX_EDGES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dsd_pkg::CMD_W-1:0]         req_command,
   input  logic [dsd_pkg::NODE_W-1:0]        req_node,
   input  logic [dsd_pkg::OFFSET_W-1:0]      req_offset,
   input  logic [dsd_pkg::NBR_W-1:0]         req_neighbor,
   input  logic [dsd_pkg::WEIGHT_W-1:0]      req_weight,
   input  logic [dsd_pkg::TAG_W-1:0]         req_tag,
   input  logic                              csr_we,
   input  logic [dsd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dsd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output dsd_pkg::cfg_type                  cfg,
   output logic                              q_valid,
   output dsd_pkg::item_type                 q_item,
   input  logic                              q_pop
);

   logic [dsd_pkg::NODE_W-1:0] node_count_ff, node_count_in;
   logic                       filter_en_ff, filter_en_in;
   logic [dsd_pkg::TAG_W-1:0]  filter_tag_ff, filter_tag_in;

   dsd_pkg::item_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   dsd_pkg::item_type new_item;
   logic              push;
   logic [dsd_pkg::NODE_W-1:0] lim;

   always_comb begin
      node_count_in = node_count_ff;
      filter_en_in  = filter_en_ff;
      filter_tag_in = filter_tag_ff;
      if (csr_we) begin
         unique case (csr_index)
            dsd_pkg::CSR_NODE_COUNT: node_count_in = csr_wdata;
            dsd_pkg::CSR_FILTER_EN:  filter_en_in  = csr_wdata[0];
            dsd_pkg::CSR_FILTER_TAG: filter_tag_in = csr_wdata[dsd_pkg::TAG_W-1:0];
            default: ;
         endcase
      end
   end

   // Node counts above the storage size act as the storage size.
   assign lim = (32'(node_count_ff) > MAX_NODES) ? dsd_pkg::NODE_W'(MAX_NODES)
                                                 : node_count_ff;
   assign cfg = '{node_lim: lim, filter_en: filter_en_ff, filter_tag: filter_tag_ff};

   always_comb begin
      new_item.cmd    = req_command;
      new_item.node   = req_node;
      new_item.offset = req_offset;
      new_item.nbr    = req_neighbor;
      new_item.weight = req_weight;
      new_item.tag    = req_tag;
      unique case (req_command)
         dsd_pkg::CMD_WR_OFFSET:
            new_item.err = (32'(req_node) > MAX_NODES) || (32'(req_offset) > MAX_EDGES);
         dsd_pkg::CMD_WR_EDGE: new_item.err = 32'(req_offset) >= MAX_EDGES;
         dsd_pkg::CMD_WR_TAG:  new_item.err = 32'(req_node) >= MAX_NODES;
         dsd_pkg::CMD_RUN, dsd_pkg::CMD_READ: new_item.err = req_node >= lim;
         default: new_item.err = 1'b1;
      endcase
   end

   assign busy    = count_ff == 2'd2;
   assign push    = start && !busy;
   assign q_valid = count_ff != 2'd0;
   assign q_item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= dsd_pkg::NODE_W'(1);
         filter_en_ff  <= 1'b0;
         filter_tag_ff <= '0;
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         count_ff      <= 2'd0;
      end else begin
         node_count_ff <= node_count_in;
         filter_en_ff  <= filter_en_in;
         filter_tag_ff <= filter_tag_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* rtl/dsd_back.sv */
// Back end: store updates, distance reads and the heap-based shortest-path run.
module dsd_back #(
   parameter int MAX_NODES = 256,
   parameter int MAX_EDGES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dsd_pkg::cfg_type              cfg,
   input  logic                          q_valid,
   input  dsd_pkg::item_type             q_item,
   output logic                          q_pop,
   output logic                          rsp_valid,
   output logic [dsd_pkg::DIST_W-1:0]    rsp_distance,
   output logic                          rsp_reached,
   output logic                          rsp_error
);

   localparam int NODE_AW    = $clog2(MAX_NODES);
   localparam int ROW_DEPTH  = MAX_NODES + 1;
   localparam int ROW_AW     = $clog2(ROW_DEPTH);
   localparam int EDGE_AW    = $clog2(MAX_EDGES);
   localparam int HEAP_DEPTH = MAX_EDGES + 1;
   localparam int HEAP_AW    = $clog2(HEAP_DEPTH);
   localparam int HSZ_W      = $clog2(HEAP_DEPTH + 1);
   localparam int KEY_W      = dsd_pkg::DIST_W + NODE_AW;
   localparam int DW         = dsd_pkg::DIST_W;

   dsd_pkg::state_type state_ff, state_in;
   dsd_pkg::item_type  cur_ff, cur_in;
   logic [KEY_W-1:0]   top_ff, top_in, last_ff, last_in, cval_ff, cval_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [HEAP_AW-1:0] k_ff, k_in, best_ff, best_in, p_ff, p_in;
   logic [HSZ_W-1:0]   size_ff, size_in;
   logic [dsd_pkg::OFFSET_W-1:0] s_ff, s_in, e_ff, e_in;
   logic [NODE_AW-1:0] v_ff, v_in;
   logic [DW-1:0]      sum_ff, sum_in;
   logic [MAX_NODES-1:0] vld_ff, vld_in;
   logic               rsp_valid_ff, rsp_valid_in, rsp_reached_ff, rsp_reached_in;
   logic               rsp_error_ff, rsp_error_in;
   logic [DW-1:0]      rsp_dist_ff, rsp_dist_in;

   logic                          row_we, edge_we, tag_we, dist_we, heap_we;
   logic [ROW_AW-1:0]             row_waddr, row_raddr;
   logic [dsd_pkg::OFFSET_W-1:0]  row_wdata, row_rdata;
   logic [EDGE_AW-1:0]            edge_waddr, edge_raddr;
   logic [dsd_pkg::EDGE_W-1:0]    edge_wdata, edge_rdata;
   logic [NODE_AW-1:0]            tag_waddr, tag_raddr, dist_waddr, dist_raddr;
   logic [dsd_pkg::TAG_W-1:0]     tag_wdata, tag_rdata;
   logic [DW-1:0]                 dist_wdata, dist_rdata;
   logic [HEAP_AW-1:0]            heap_waddr, heap_raddr;
   logic [KEY_W-1:0]              heap_wdata, heap_rdata;

   logic [NODE_AW-1:0] top_node;
   logic [DW-1:0]      top_dist, dv;
   logic [HEAP_AW:0]   child;
   logic [DW:0]        raw_sum;
   logic [dsd_pkg::NBR_W-1:0] e_nbr;

   dsd_ram #(.WIDTH(dsd_pkg::OFFSET_W), .DEPTH(ROW_DEPTH)) u_row (
      .clock, .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
      .raddr(row_raddr), .rdata(row_rdata));
   dsd_ram #(.WIDTH(dsd_pkg::EDGE_W), .DEPTH(MAX_EDGES)) u_edge (
      .clock, .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
      .raddr(edge_raddr), .rdata(edge_rdata));
   dsd_ram #(.WIDTH(dsd_pkg::TAG_W), .DEPTH(MAX_NODES)) u_tag (
      .clock, .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
      .raddr(tag_raddr), .rdata(tag_rdata));
   dsd_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dist (
      .clock, .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
      .raddr(dist_raddr), .rdata(dist_rdata));
   dsd_ram #(.WIDTH(KEY_W), .DEPTH(HEAP_DEPTH)) u_heap (
      .clock, .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
      .raddr(heap_raddr), .rdata(heap_rdata));

   assign top_node = top_ff[NODE_AW-1:0];
   assign top_dist = top_ff[KEY_W-1:NODE_AW];
   assign child    = {k_ff, 1'b1};
   assign e_nbr    = edge_rdata[dsd_pkg::EDGE_W-1:dsd_pkg::WEIGHT_W];
   assign raw_sum  = (DW+1)'(top_dist) + (DW+1)'(edge_rdata[dsd_pkg::WEIGHT_W-1:0]);

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;  top_in = top_ff;  last_in = last_ff;  cval_in = cval_ff;
      key_in = key_ff;  k_in = k_ff;  best_in = best_ff;  p_in = p_ff;
      size_in = size_ff;  s_in = s_ff;  e_in = e_ff;  v_in = v_ff;  sum_in = sum_ff;
      vld_in = vld_ff;
      rsp_valid_in = 1'b0;  rsp_dist_in = rsp_dist_ff;
      rsp_reached_in = rsp_reached_ff;  rsp_error_in = rsp_error_ff;
      q_pop = 1'b0;
      row_we = 1'b0;  row_waddr = ROW_AW'(q_item.node);  row_wdata = q_item.offset;
      row_raddr = ROW_AW'(top_node);
      edge_we = 1'b0;  edge_waddr = EDGE_AW'(q_item.offset);
      edge_wdata = {q_item.nbr, q_item.weight};  edge_raddr = EDGE_AW'(s_ff);
      tag_we = 1'b0;  tag_waddr = NODE_AW'(q_item.node);  tag_wdata = q_item.tag;
      tag_raddr = NODE_AW'(e_nbr);
      dist_we = 1'b0;  dist_waddr = v_ff;  dist_wdata = sum_ff;
      dist_raddr = top_node;
      heap_we = 1'b0;  heap_waddr = k_ff;  heap_wdata = last_ff;  heap_raddr = '0;
      dv = vld_ff[v_ff] ? dist_rdata : dsd_pkg::DIST_ONES;

      unique case (state_ff)
         dsd_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               rsp_reached_in = 1'b0;
               rsp_error_in   = q_item.err;
               rsp_dist_in    = dsd_pkg::DIST_ONES;
               if (q_item.cmd == dsd_pkg::CMD_WR_OFFSET || q_item.cmd == dsd_pkg::CMD_WR_EDGE
                   || q_item.cmd == dsd_pkg::CMD_WR_TAG) begin
                  rsp_dist_in = '0;
               end
               if (q_item.err) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  unique case (q_item.cmd)
                     dsd_pkg::CMD_WR_OFFSET: begin
                        row_we = 1'b1;  rsp_valid_in = 1'b1;
                     end
                     dsd_pkg::CMD_WR_EDGE: begin
                        edge_we = 1'b1;  rsp_valid_in = 1'b1;
                     end
                     dsd_pkg::CMD_WR_TAG: begin
                        tag_we = 1'b1;  rsp_valid_in = 1'b1;
                     end
                     dsd_pkg::CMD_READ: begin
                        dist_raddr = NODE_AW'(q_item.node);
                        state_in = dsd_pkg::ST_RD_DONE;
                     end
                     dsd_pkg::CMD_RUN: state_in = dsd_pkg::ST_RUN_INIT;
                     default: rsp_valid_in = 1'b1;
                  endcase
               end
            end
         end
         dsd_pkg::ST_RD_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_dist_in  = vld_ff[NODE_AW'(cur_ff.node)] ? dist_rdata : dsd_pkg::DIST_ONES;
            rsp_reached_in = rsp_dist_in != dsd_pkg::DIST_ONES;
            state_in = dsd_pkg::ST_IDLE;
         end
         dsd_pkg::ST_RUN_INIT: begin
            // All distances fall back to unreachable; only the source is seeded.
            vld_in = '0;
            vld_in[NODE_AW'(cur_ff.node)] = 1'b1;
            dist_we = 1'b1;  dist_waddr = NODE_AW'(cur_ff.node);  dist_wdata = '0;
            heap_we = 1'b1;  heap_waddr = '0;
            heap_wdata = {{DW{1'b0}}, NODE_AW'(cur_ff.node)};
            size_in = HSZ_W'(1);
            state_in = dsd_pkg::ST_POP;
         end
         dsd_pkg::ST_POP: begin
            heap_raddr = '0;
            state_in = (size_ff == '0) ? dsd_pkg::ST_RUN_DONE : dsd_pkg::ST_POP_TOP;
         end
         dsd_pkg::ST_POP_TOP: begin
            top_in  = heap_rdata;
            size_in = size_ff - HSZ_W'(1);
            heap_raddr = HEAP_AW'(size_in);
            state_in = dsd_pkg::ST_POP_LAST;
         end
         dsd_pkg::ST_POP_LAST: begin
            last_in = heap_rdata;
            k_in = '0;
            state_in = dsd_pkg::ST_SIFT;
         end
         dsd_pkg::ST_SIFT: begin
            if (32'(child) >= 32'(size_ff)) begin
               heap_we = size_ff != '0;
               state_in = dsd_pkg::ST_CHECK;
            end else begin
               heap_raddr = HEAP_AW'(child);
               state_in = dsd_pkg::ST_SIFT_L;
            end
         end
         dsd_pkg::ST_SIFT_L: begin
            cval_in = heap_rdata;
            best_in = HEAP_AW'(child);
            heap_raddr = HEAP_AW'(child + 1'b1);
            state_in = (32'(child) + 1 < 32'(size_ff)) ? dsd_pkg::ST_SIFT_R
                                                      : dsd_pkg::ST_SIFT_CMP;
         end
         dsd_pkg::ST_SIFT_R: begin
            if (heap_rdata < cval_ff) begin
               cval_in = heap_rdata;
               best_in = HEAP_AW'(child + 1'b1);
            end
            state_in = dsd_pkg::ST_SIFT_CMP;
         end
         dsd_pkg::ST_SIFT_CMP: begin
            heap_we = 1'b1;
            if (last_ff <= cval_ff) begin
               state_in = dsd_pkg::ST_CHECK;
            end else begin
               heap_wdata = cval_ff;
               k_in = best_ff;
               state_in = dsd_pkg::ST_SIFT;
            end
         end
         dsd_pkg::ST_CHECK: begin
            state_in = (dsd_pkg::NODE_W'(top_node) >= cfg.node_lim) ? dsd_pkg::ST_POP
                                                                    : dsd_pkg::ST_CHECK_DIST;
         end
         dsd_pkg::ST_CHECK_DIST: begin
            // Lazy deletion: a stale heap entry is dropped here.
            if (top_dist > (vld_ff[top_node] ? dist_rdata : dsd_pkg::DIST_ONES)) begin
               state_in = dsd_pkg::ST_POP;
            end else begin
               state_in = dsd_pkg::ST_ROW_S;
            end
         end
         dsd_pkg::ST_ROW_S: begin
            s_in = row_rdata;
            row_raddr = ROW_AW'(top_node) + ROW_AW'(1);
            state_in = dsd_pkg::ST_ROW_E;
         end
         dsd_pkg::ST_ROW_E: begin
            e_in = (32'(row_rdata) > MAX_EDGES) ? dsd_pkg::OFFSET_W'(MAX_EDGES) : row_rdata;
            state_in = dsd_pkg::ST_EDGE;
         end
         dsd_pkg::ST_EDGE: begin
            state_in = (s_ff >= e_ff) ? dsd_pkg::ST_POP : dsd_pkg::ST_EDGE_RD;
         end
         dsd_pkg::ST_EDGE_RD: begin
            v_in   = NODE_AW'(e_nbr);
            sum_in = (raw_sum >= (DW+1)'(dsd_pkg::DIST_ONES))
                     ? dsd_pkg::DIST_ONES - DW'(1) : raw_sum[DW-1:0];
            dist_raddr = NODE_AW'(e_nbr);
            if (dsd_pkg::NODE_W'(e_nbr) >= cfg.node_lim) begin
               s_in = s_ff + 1'b1;
               state_in = dsd_pkg::ST_EDGE;
            end else begin
               state_in = dsd_pkg::ST_RELAX;
            end
         end
         dsd_pkg::ST_RELAX: begin
            if ((cfg.filter_en && tag_rdata != cfg.filter_tag) || dv <= sum_ff) begin
               s_in = s_ff + 1'b1;
               state_in = dsd_pkg::ST_EDGE;
            end else begin
               dist_we = 1'b1;
               vld_in[v_ff] = 1'b1;
               if (32'(size_ff) >= HEAP_DEPTH) begin
                  s_in = s_ff + 1'b1;
                  state_in = dsd_pkg::ST_EDGE;
               end else begin
                  k_in = HEAP_AW'(size_ff);
                  size_in = size_ff + HSZ_W'(1);
                  key_in = {sum_ff, v_ff};
                  state_in = dsd_pkg::ST_PUSH;
               end
            end
         end
         dsd_pkg::ST_PUSH: begin
            p_in = HEAP_AW'((k_ff - 1'b1) >> 1);
            heap_raddr = p_in;
            if (k_ff == '0) begin
               heap_we = 1'b1;  heap_wdata = key_ff;
               s_in = s_ff + 1'b1;
               state_in = dsd_pkg::ST_EDGE;
            end else begin
               state_in = dsd_pkg::ST_PUSH_CMP;
            end
         end
         dsd_pkg::ST_PUSH_CMP: begin
            heap_we = 1'b1;
            if (heap_rdata <= key_ff) begin
               heap_wdata = key_ff;
               s_in = s_ff + 1'b1;
               state_in = dsd_pkg::ST_EDGE;
            end else begin
               heap_wdata = heap_rdata;
               k_in = p_ff;
               state_in = dsd_pkg::ST_PUSH;
            end
         end
         dsd_pkg::ST_RUN_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_dist_in = '0;
            rsp_reached_in = 1'b1;
            rsp_error_in = 1'b0;
            state_in = dsd_pkg::ST_IDLE;
         end
         default: state_in = dsd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsd_pkg::ST_IDLE;
         vld_ff       <= '0;
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;  top_ff <= top_in;  last_ff <= last_in;  cval_ff <= cval_in;
      key_ff <= key_in;  k_ff <= k_in;  best_ff <= best_in;  p_ff <= p_in;
      s_ff <= s_in;  e_ff <= e_in;  v_ff <= v_in;  sum_ff <= sum_in;
      rsp_dist_ff <= rsp_dist_in;  rsp_reached_ff <= rsp_reached_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_reached  = rsp_reached_ff;
   assign rsp_error    = rsp_error_ff;

   a_heap_bound: assert property (@(posedge clock) disable iff (reset)
      32'(size_ff) <= HEAP_DEPTH)
      else $error("heap size beyond heap depth");

   a_relax_finite: assert property (@(posedge clock) disable iff (reset)
      (dist_we && state_ff == dsd_pkg::ST_RELAX) |-> (dist_wdata != dsd_pkg::DIST_ONES))
      else $error("relaxation wrote an unreachable distance");

   a_relax_lower: assert property (@(posedge clock) disable iff (reset)
      (dist_we && state_ff == dsd_pkg::ST_RELAX) |-> (sum_ff < dv))
      else $error("relaxation did not lower the distance");

   a_reached_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reached) |-> (!rsp_error && rsp_distance != dsd_pkg::DIST_ONES))
      else $error("reached word carries an error or no distance");

endmodule

/* rtl/dijkstra_shortest_distance_core.sv */
// Top level of the single-source shortest-distance core.
//
//  channel   ports                          handshake
//  request   req_command .. req_tag         start, busy
//  response  rsp_distance, reached, error   rsp_valid strobe, one cycle
//  config    csr_index, csr_wdata           csr_we
//
// With the back end idle, writes and error words answer from its idle state, reads after the
// ST_RD_DONE state; a word waiting in the queue adds the time of the word ahead of it.
// A run pops and sifts the heap one RAM access per cycle: each pop reads the top and last
// entries and sifts down, a live node's row bounds are fetched, and each edge is scanned,
// its neighbour's tag and distance read and, if lowered, the neighbour pushed and sifted up.
// Reset is synchronous; all distances read as unreachable after it, stores are unset.
// A two-word queue lets new words be taken while the back end works; busy marks it full.
// Responses cannot be held off.
module dijkstra_shortest_distance_core #(
   parameter int MAX_NODES = 256,
   parameter int MAX_EDGES = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [dsd_pkg::CMD_W-1:0]      req_command,
   input  logic [dsd_pkg::NODE_W-1:0]     req_node,
   input  logic [dsd_pkg::OFFSET_W-1:0]   req_offset,
   input  logic [dsd_pkg::NBR_W-1:0]      req_neighbor,
   input  logic [dsd_pkg::WEIGHT_W-1:0]   req_weight,
   input  logic [dsd_pkg::TAG_W-1:0]      req_tag,
   output logic                           rsp_valid,
   output logic [dsd_pkg::DIST_W-1:0]     rsp_distance,
   output logic                           rsp_reached,
   output logic                           rsp_error,
   input  logic                           csr_we,
   input  logic [dsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dsd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   dsd_pkg::cfg_type  cfg;
   dsd_pkg::item_type q_item;
   logic              q_valid, q_pop;

   dsd_front #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_front (
      .clock, .reset, .start, .busy, .req_command, .req_node, .req_offset,
      .req_neighbor, .req_weight, .req_tag, .csr_we, .csr_index, .csr_wdata,
      .cfg, .q_valid, .q_item, .q_pop);

   dsd_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_back (
      .clock, .reset, .cfg, .q_valid, .q_item, .q_pop,
      .rsp_valid, .rsp_distance, .rsp_reached, .rsp_error);

endmodule
